@@ hw/rtl/ciht_pkg.sv @@
// Shared constants for the chained integer hash table.
// Depends on nothing.
package ciht_pkg;
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [3:0] BITS_RESET = 4'd8;
endpackage

@@ hw/rtl/ciht_if.sv @@
// Valid/ready channel interfaces for the hash table.
// Depends on nothing.
interface ciht_req_if;
    logic valid;
    logic ready;
    logic [1:0] opcode;
    logic signed [31:0] key;
    logic [31:0] value;
    modport source (output valid, opcode, key, value, input ready);
    modport sink (input valid, opcode, key, value, output ready);
endinterface

interface ciht_rsp_if;
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [31:0] value_out;
    modport source (output valid, status, value_out, input ready);
    modport sink (input valid, status, value_out, output ready);
endinterface

interface ciht_cfg_if;
    logic valid;
    logic ready;
    logic [3:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/chained_int_hash_table_top.sv @@
// Top level of the chained integer hash table.
// Depends on ciht_pkg, ciht_if, ciht_front and ciht_back.
// One item at a time is carried out by the back sequencer: an add passes the head,
// free (when a recycled cell is popped from the free stack), link and output states;
// a lookup or remove passes head, then read and compare per chain cell visited, one
// cell memory read each, then output; an untaken result holds the sequencer there.
// A two-entry queue in front lets items be accepted while the back is busy.
module chained_int_hash_table_top #(
    parameter int BUCKET_BITS = 8,
    parameter int CELL_COUNT = 256
) (
    input logic clk,
    input logic rst_n,
    ciht_req_if.sink req,
    ciht_rsp_if.source rsp,
    ciht_cfg_if.sink cfg
);
    logic [3:0] bits_reg;
    logic q_valid, q_pop;
    logic [1:0] q_op;
    logic [31:0] q_key, q_val;
    logic [BUCKET_BITS-1:0] q_bkt;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) bits_reg <= ciht_pkg::BITS_RESET;
        else if (cfg.valid) bits_reg <= cfg.data;
    end

    ciht_front #(.BUCKET_BITS(BUCKET_BITS)) u_front (
        .clk, .rst_n, .req, .bits_used(bits_reg), .q_valid, .q_pop,
        .q_op, .q_key, .q_val, .q_bkt
    );

    ciht_back #(.BUCKET_BITS(BUCKET_BITS), .CELL_COUNT(CELL_COUNT)) u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_op, .q_key, .q_val, .q_bkt, .rsp
    );
endmodule

@@ hw/rtl/ciht_front.sv @@
// Front part: accepts items, computes the bucket and queues them.
// Depends on ciht_pkg and ciht_if.
module ciht_front #(
    parameter int BUCKET_BITS = 8
) (
    input  logic clk,
    input  logic rst_n,
    ciht_req_if.sink req,
    input  logic [3:0] bits_used,
    output logic q_valid,
    input  logic q_pop,
    output logic [1:0] q_op,
    output logic [31:0] q_key,
    output logic [31:0] q_val,
    output logic [BUCKET_BITS-1:0] q_bkt
);
    localparam int QD = 2;
    localparam int W = 2 + 32 + 32 + BUCKET_BITS;
    logic [W-1:0] mem [QD];
    logic [1:0] cnt_reg;
    logic rd_reg;
    logic wr_reg;
    logic [3:0] eb;
    logic [BUCKET_BITS-1:0] bkt;
    logic push;

    always_comb
    begin
        eb = bits_used;
        if (eb == 4'd0) eb = 4'd1;
        if (32'(eb) > BUCKET_BITS) eb = 4'(BUCKET_BITS);
        for (int i = 0; i < BUCKET_BITS; i++)
            bkt[i] = req.key[i] & (i < int'(eb));
    end

    assign req.ready = (cnt_reg < 2'(QD));
    assign push = req.valid && req.ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign {q_op, q_key, q_val, q_bkt} = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_reg] <= {req.opcode, req.key, req.value, bkt};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push) wr_reg <= ~wr_reg;
            if (q_pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    a_nooverflow: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QD))
        else $error("queue overflow");
    a_popvalid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count mismatch");
endmodule

@@ hw/rtl/ciht_back.sv @@
// Back part: executes items against the bucket and cell memories.
// Depends on ciht_pkg and ciht_if.
module ciht_back #(
    parameter int BUCKET_BITS = 8,
    parameter int CELL_COUNT = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_pop,
    input  logic [1:0] q_op,
    input  logic [31:0] q_key,
    input  logic [31:0] q_val,
    input  logic [BUCKET_BITS-1:0] q_bkt,
    ciht_rsp_if.source rsp
);
    localparam int CW = $clog2(CELL_COUNT);
    localparam int NB = 1 << BUCKET_BITS;
    localparam int FW = $clog2(CELL_COUNT + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_HEAD = 7'b0000010, S_FREE = 7'b0000100,
        S_RD = 7'b0001000, S_CMP = 7'b0010000, S_OUT = 7'b0100000,
        S_LINK = 7'b1000000
    } state_t;

    // Each next link carries its valid flag in the top bit.
    logic [CW-1:0] head_mem [NB];
    logic [NB-1:0] hv_reg;
    logic [31:0] key_mem [CELL_COUNT];
    logic [31:0] val_mem [CELL_COUNT];
    logic [CW:0] nxt_mem [CELL_COUNT];
    logic [CW-1:0] fs_mem [CELL_COUNT];

    state_t st_reg;
    logic [FW-1:0] ftop_reg, fresh_reg;
    logic [CW-1:0] head_rd, fs_rd, cur_reg, prev_reg, newc_reg;
    logic hprev_reg;
    logic [31:0] ck_rd, cv_rd;
    logic [CW:0] cn_rd;
    logic [1:0] wst_reg;
    logic [31:0] wvo_reg;
    logic [1:0] st_out_reg;
    logic [31:0] vo_reg;
    logic ov_reg;

    assign rsp.valid = ov_reg;
    assign rsp.status = st_out_reg;
    assign rsp.value_out = vo_reg;
    assign q_pop = (st_reg == S_OUT) && (!ov_reg || rsp.ready);

    always_ff @(posedge clk)
    begin
        head_rd <= head_mem[q_bkt];
        fs_rd <= fs_mem[CW'(ftop_reg - FW'(1))];
        ck_rd <= key_mem[cur_reg];
        cv_rd <= val_mem[cur_reg];
        cn_rd <= nxt_mem[cur_reg];
        if (st_reg == S_LINK)
        begin
            key_mem[newc_reg] <= q_key;
            val_mem[newc_reg] <= q_val;
            nxt_mem[newc_reg] <= {hv_reg[q_bkt], head_rd};
            head_mem[q_bkt] <= newc_reg;
        end
        if (st_reg == S_CMP && q_op == ciht_pkg::OP_REMOVE && ck_rd == q_key)
        begin
            if (hprev_reg) nxt_mem[prev_reg] <= cn_rd;
            else head_mem[q_bkt] <= cn_rd[CW-1:0];
            if (ftop_reg < FW'(CELL_COUNT)) fs_mem[CW'(ftop_reg)] <= cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            hv_reg <= '0;
            ftop_reg <= '0;
            fresh_reg <= '0;
            ov_reg <= 1'b0;
            hprev_reg <= 1'b0;
            cur_reg <= '0;
            prev_reg <= '0;
            newc_reg <= '0;
            wst_reg <= '0;
            wvo_reg <= '0;
            st_out_reg <= '0;
            vo_reg <= '0;
        end
        else
        begin
            if (ov_reg && rsp.ready && st_reg != S_OUT) ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                    if (q_valid) st_reg <= S_HEAD;
                S_HEAD:
                begin
                    hprev_reg <= 1'b0;
                    wst_reg <= ciht_pkg::ST_MISS;
                    wvo_reg <= '0;
                    if (q_op == ciht_pkg::OP_ADD)
                    begin
                        if (ftop_reg != '0) st_reg <= S_FREE;
                        else if (fresh_reg < FW'(CELL_COUNT))
                        begin
                            newc_reg <= CW'(fresh_reg);
                            fresh_reg <= fresh_reg + FW'(1);
                            st_reg <= S_LINK;
                        end
                        else
                        begin
                            wst_reg <= ciht_pkg::ST_FULL;
                            st_reg <= S_OUT;
                        end
                    end
                    else if (q_op == ciht_pkg::OP_LOOKUP || q_op == ciht_pkg::OP_REMOVE)
                    begin
                        cur_reg <= head_rd;
                        st_reg <= hv_reg[q_bkt] ? S_RD : S_OUT;
                    end
                    else
                    begin
                        wst_reg <= ciht_pkg::ST_OK;
                        st_reg <= S_OUT;
                    end
                end
                S_FREE:
                begin
                    newc_reg <= fs_rd;
                    ftop_reg <= ftop_reg - FW'(1);
                    st_reg <= S_LINK;
                end
                S_LINK:
                begin
                    hv_reg[q_bkt] <= 1'b1;
                    wst_reg <= ciht_pkg::ST_OK;
                    wvo_reg <= q_val;
                    st_reg <= S_OUT;
                end
                S_RD:
                    st_reg <= S_CMP;
                S_CMP:
                begin
                    if (ck_rd == q_key)
                    begin
                        wst_reg <= ciht_pkg::ST_OK;
                        if (q_op == ciht_pkg::OP_LOOKUP) wvo_reg <= cv_rd;
                        else
                        begin
                            if (!hprev_reg) hv_reg[q_bkt] <= cn_rd[CW];
                            if (ftop_reg < FW'(CELL_COUNT)) ftop_reg <= ftop_reg + FW'(1);
                        end
                        st_reg <= S_OUT;
                    end
                    else if (cn_rd[CW])
                    begin
                        prev_reg <= cur_reg;
                        hprev_reg <= 1'b1;
                        cur_reg <= cn_rd[CW-1:0];
                        st_reg <= S_RD;
                    end
                    else st_reg <= S_OUT;
                end
                S_OUT:
                    if (!ov_reg || rsp.ready)
                    begin
                        ov_reg <= 1'b1;
                        st_out_reg <= wst_reg;
                        vo_reg <= wvo_reg;
                        st_reg <= S_IDLE;
                    end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_reg))
        else $error("state not one-hot");
    a_ftop: assert property (@(posedge clk) disable iff (!rst_n) ftop_reg <= fresh_reg)
        else $error("free stack deeper than cells handed out");
    a_fullval: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ciht_pkg::ST_OK) |-> rsp.value_out == '0)
        else $error("nonzero value on failure");
endmodule

@@ tb/ciht_scoreboard.sv @@
// Scoreboard class for the chained integer hash table testbench.
// Holds a software copy of the table and a queue of expected results; uses ciht_pkg.
`timescale 1ns / 1ps

class ciht_scoreboard;
    logic [31:0] key_mem [256];
    logic [31:0] val_mem [256];
    logic [8:0]  next_mem [256];
    logic [8:0]  head_mem [256];
    logic [7:0]  free_mem [256];
    int unsigned free_top;
    int unsigned fresh_count;
    logic [3:0]  width_reg;
    logic [1:0]  status_q [$];
    logic [31:0] value_q [$];
    int          errors;

    function void clear();
        for (int i = 0; i < 256; i++)
        begin
            head_mem[i] = 9'd0;
            key_mem[i] = '0;
            val_mem[i] = '0;
            next_mem[i] = '0;
            free_mem[i] = '0;
        end
        free_top = 0;
        fresh_count = 0;
        width_reg = ciht_pkg::BITS_RESET;
        errors = 0;
    endfunction

    function void set_width(logic [3:0] w);
        width_reg = w;
    endfunction

    function int unsigned bucket_of(logic [31:0] k);
        int unsigned bits;
        bits = width_reg;
        if (bits < 1)
            bits = 1;
        if (bits > 8)
            bits = 8;
        return k & ((1 << bits) - 1);
    endfunction

    // Bit 8 of a head or next link is its valid flag.
    function void note_request(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        int unsigned b;
        int unsigned c;
        int unsigned steps;
        logic [8:0] cur;
        logic [8:0] prev;
        logic [1:0] st;
        logic [31:0] vo;
        b = bucket_of(k);
        st = ciht_pkg::ST_OK;
        vo = '0;
        if (op == ciht_pkg::OP_ADD)
        begin
            c = 256;
            if (free_top > 0)
            begin
                free_top--;
                c = free_mem[free_top];
            end
            else if (fresh_count < 256)
            begin
                c = fresh_count;
                fresh_count++;
            end
            if (c < 256)
            begin
                key_mem[c] = k;
                val_mem[c] = v;
                next_mem[c] = head_mem[b];
                head_mem[b] = {1'b1, 8'(c)};
                vo = v;
            end
            else
                st = ciht_pkg::ST_FULL;
        end
        else if (op == ciht_pkg::OP_LOOKUP || op == ciht_pkg::OP_REMOVE)
        begin
            st = ciht_pkg::ST_MISS;
            cur = head_mem[b];
            prev = '0;
            steps = 0;
            while (cur[8] && steps < 256)
            begin
                if (key_mem[cur[7:0]] == k)
                begin
                    st = ciht_pkg::ST_OK;
                    if (op == ciht_pkg::OP_LOOKUP)
                        vo = val_mem[cur[7:0]];
                    else
                    begin
                        if (prev[8])
                            next_mem[prev[7:0]] = next_mem[cur[7:0]];
                        else
                            head_mem[b] = next_mem[cur[7:0]];
                        if (free_top < 256)
                        begin
                            free_mem[free_top] = cur[7:0];
                            free_top++;
                        end
                    end
                    break;
                end
                prev = cur;
                cur = next_mem[cur[7:0]];
                steps++;
            end
        end
        status_q.push_back(st);
        value_q.push_back(vo);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] vo);
        logic [1:0] est;
        logic [31:0] evo;
        if (status_q.size() == 0)
        begin
            $error("unexpected result: status %0d value_out %h", st, vo);
            errors++;
            return;
        end
        est = status_q.pop_front();
        evo = value_q.pop_front();
        if (st !== est)
        begin
            $error("status: expected %0d actual %0d", est, st);
            errors++;
        end
        if (vo !== evo)
        begin
            $error("value_out: expected %h actual %h", evo, vo);
            errors++;
        end
    endfunction

    function int pending();
        return status_q.size();
    endfunction
endclass

@@ tb/tb_chained_int_hash_table_top.sv @@
// Top-level testbench for chained_int_hash_table_top.
// Drives requests and width writes with random idling and checks every result
// against the ciht_scoreboard class; depends on ciht_pkg and ciht_if.
`timescale 1ns / 1ps

module tb_chained_int_hash_table_top;
    logic clk;
    logic rst_n;
    int   send_idle;
    int   recv_idle;
    int   hold_cycles;
    bit   stim_done;
    logic [31:0] used_keys [$];

    ciht_req_if req ();
    ciht_rsp_if rsp ();
    ciht_cfg_if cfg ();

    ciht_scoreboard table_model;

    chained_int_hash_table_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_item(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= op;
        req.key <= k;
        req.value <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        table_model.note_request(op, k, v);
        if (op == ciht_pkg::OP_ADD)
            used_keys.push_back(k);
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        while (table_model.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_width(logic [3:0] w);
        wait_drain();
        cfg.valid <= 1'b1;
        cfg.data <= w;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        table_model.set_width(w);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_key(int unsigned kbits);
        logic [31:0] k;
        if (used_keys.size() != 0 && $urandom_range(99) < 60)
            k = used_keys[$urandom_range(used_keys.size() - 1)];
        else if ($urandom_range(3) == 0)
            k = $urandom();
        else
            k = $urandom_range((1 << kbits) - 1) | ($urandom_range(1) ? 32'h8000_0000 : 0);
        return k;
    endfunction

    task automatic random_items(int n, int unsigned kbits);
        int r;
        logic [1:0] op;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                op = ciht_pkg::OP_ADD;
            else if (r < 72)
                op = ciht_pkg::OP_LOOKUP;
            else if (r < 97)
                op = ciht_pkg::OP_REMOVE;
            else
                op = ciht_pkg::OP_UNUSED;
            send_item(op, pick_key(kbits), $urandom());
        end
    endtask

    initial
    begin
        table_model = new();
        table_model.clear();
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.opcode = ciht_pkg::OP_LOOKUP;
        req.key = '0;
        req.value = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        send_idle = 38;
        recv_idle = 73;
        hold_cycles = 0;
        stim_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        send_item(ciht_pkg::OP_LOOKUP, 32'h0, 32'h0);
        send_item(ciht_pkg::OP_REMOVE, 32'h0, 32'h0);
        send_item(ciht_pkg::OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(ciht_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0);
        send_item(ciht_pkg::OP_ADD, 32'hFFFF_FF00, 32'h1111_1111);
        send_item(ciht_pkg::OP_ADD, 32'h8000_0000, 32'h2222_2222);
        send_item(ciht_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0);
        send_item(ciht_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_item(ciht_pkg::OP_REMOVE, 32'h8000_0000, 32'h0);
        send_item(ciht_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0);
        send_item(ciht_pkg::OP_REMOVE, 32'hFFFF_FF00, 32'h0);
        send_item(ciht_pkg::OP_UNUSED, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
        send_item(ciht_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        write_width(4'd0);
        send_item(ciht_pkg::OP_ADD, 32'h0000_0003, 32'h3333_3333);
        send_item(ciht_pkg::OP_LOOKUP, 32'h0000_0003, 32'h0);
        send_item(ciht_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0);
        write_width(4'd15);
        send_item(ciht_pkg::OP_LOOKUP, 32'h0000_0003, 32'h0);
        send_item(ciht_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);

        send_idle = 38;
        recv_idle = 73;
        write_width(4'd1);
        random_items(85, 4);
        send_idle = 73;
        recv_idle = 38;
        write_width(4'd3);
        random_items(85, 6);
        wait_drain();

        // Exhaust the pool, then hit the full case and recycle a few cells.
        send_idle = 0;
        recv_idle = 0;
        write_width(4'd8);
        hold_cycles = 200;
        for (int i = 0; i < 258; i++)
            send_item(ciht_pkg::OP_ADD, $urandom(), $urandom());
        send_item(ciht_pkg::OP_ADD, 32'h5, 32'h5);
        send_item(ciht_pkg::OP_REMOVE, used_keys[10], 32'h0);
        send_item(ciht_pkg::OP_REMOVE, used_keys[20], 32'h0);
        send_item(ciht_pkg::OP_ADD, 32'h1234_5678, 32'hCAFE_F00D);
        send_item(ciht_pkg::OP_LOOKUP, 32'h1234_5678, 32'h0);
        req.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
                table_model.check_result(rsp.status, rsp.value_out);
            if (hold_cycles > 0)
            begin
                rsp.ready <= 1'b0;
                hold_cycles--;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (stim_done);
        while (table_model.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (table_model.errors == 0 && table_model.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ chained_int_hash_table_top.f @@
hw/rtl/ciht_pkg.sv
hw/rtl/ciht_if.sv
hw/rtl/ciht_front.sv
hw/rtl/ciht_back.sv
hw/rtl/chained_int_hash_table_top.sv
tb/ciht_scoreboard.sv
tb/tb_chained_int_hash_table_top.sv
